// ----- sv/prq_pkg.sv -----
// Shared types, codes and default sizes for the priority ready queue.
package prq_pkg;

    localparam int REGISTRY_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int OP_FIFO_DEPTH      = 2;
    localparam int ID_W               = 16;
    localparam int PRIO_W             = 16;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_ENQUEUE  = 2'd2,
        KIND_DEQUEUE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_QUEUED    = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        OP_DONE = 2'd0,
        OP_ENQ  = 2'd1,
        OP_DEQ  = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        t_status             status;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
    } t_op;

endpackage

// ----- sv/prq_front.sv -----
// Command front end: task registry lookup, update and command classification.
module prq_front #(
    parameter int REGISTRY_DEPTH = prq_pkg::REGISTRY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_kind,
    input  logic [prq_pkg::ID_W-1:0]    i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]  i_task_priority,
    output prq_pkg::t_op                o_op
);

    logic [REGISTRY_DEPTH-1:0] r_valid;
    logic [REGISTRY_DEPTH-1:0] n_valid;
    logic [prq_pkg::ID_W-1:0]   r_id   [REGISTRY_DEPTH];
    logic [prq_pkg::PRIO_W-1:0] r_prio [REGISTRY_DEPTH];

    logic [REGISTRY_DEPTH-1:0]  match;
    logic [REGISTRY_DEPTH-1:0]  free_oh;
    logic                       hit;
    logic [prq_pkg::PRIO_W-1:0] hit_prio;
    logic                       wr_en;

    always_comb begin
        for (int i = 0; i < REGISTRY_DEPTH; i++) begin
            match[i] = r_valid[i] && (r_id[i] == i_task_id);
        end
    end

    always_comb begin
        hit_prio = '0;
        for (int i = 0; i < REGISTRY_DEPTH; i++) begin
            hit_prio = hit_prio | (match[i] ? r_prio[i] : '0);
        end
    end

    assign hit     = |match;
    assign free_oh = ~r_valid & (r_valid + 1'b1);

    always_comb begin
        o_op    = '{kind: prq_pkg::OP_DONE, status: prq_pkg::ST_OK, id: '0, prio: '0};
        n_valid = r_valid;
        wr_en   = 1'b0;
        unique case (prq_pkg::t_kind'(i_kind))
            prq_pkg::KIND_REGISTER: begin
                if (i_task_id == '0 || i_task_priority == '0) begin
                    o_op.status = prq_pkg::ST_INVALID;
                end else if (hit) begin
                    o_op.status = prq_pkg::ST_DUPLICATE;
                end else if (&r_valid) begin
                    o_op.status = prq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_valid = r_valid | free_oh;
                end
            end
            prq_pkg::KIND_REMOVE: begin
                if (i_task_id == '0) begin
                    o_op.status = prq_pkg::ST_INVALID;
                end else if (!hit) begin
                    o_op.status = prq_pkg::ST_NOT_FOUND;
                end else begin
                    n_valid = r_valid & ~match;
                end
            end
            prq_pkg::KIND_ENQUEUE: begin
                if (i_task_id == '0) begin
                    o_op.status = prq_pkg::ST_INVALID;
                end else if (!hit) begin
                    o_op.status = prq_pkg::ST_NOT_FOUND;
                end else begin
                    o_op.kind = prq_pkg::OP_ENQ;
                    o_op.id   = i_task_id;
                    o_op.prio = hit_prio;
                end
            end
            prq_pkg::KIND_DEQUEUE: begin
                o_op.kind = prq_pkg::OP_DEQ;
            end
            default: begin
                o_op.status = prq_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_accept) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            for (int i = 0; i < REGISTRY_DEPTH; i++) begin
                if (free_oh[i]) begin
                    r_id[i]   <= i_task_id;
                    r_prio[i] <= i_task_priority;
                end
            end
        end
    end

endmodule

// ----- sv/prq_op_fifo.sv -----
// Short command queue between the front end and the sorted queue.
module prq_op_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  prq_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output prq_pkg::t_op o_op,
    input  logic         i_pop
);

    localparam int D  = prq_pkg::OP_FIFO_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    prq_pkg::t_op    r_mem [D];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(D));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(D - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(D - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// ----- sv/prq_back.sv -----
// Sorted ready queue cells and result register.
module prq_back #(
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_op_valid,
    input  prq_pkg::t_op                i_op,
    output logic                        o_op_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [2:0]                  o_status,
    output logic [prq_pkg::ID_W-1:0]    o_head_id,
    output logic [prq_pkg::PRIO_W-1:0]  o_head_priority
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [prq_pkg::ID_W-1:0]   r_qid   [QUEUE_DEPTH];
    logic [prq_pkg::PRIO_W-1:0] r_qprio [QUEUE_DEPTH];
    logic [CW-1:0]              r_count;

    logic                       r_out_valid;
    prq_pkg::t_status           r_status;
    logic [prq_pkg::ID_W-1:0]   r_head_id;
    logic [prq_pkg::PRIO_W-1:0] r_head_prio;

    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] id_hit;
    logic                   q_full;
    logic                   do_ins;
    logic                   do_del;
    prq_pkg::t_status       n_status;
    logic [prq_pkg::ID_W-1:0]   n_head_id;
    logic [prq_pkg::PRIO_W-1:0] n_head_prio;

    assign o_op_take = i_op_valid && (!r_out_valid || i_pop);
    assign q_full    = (r_count == CW'(QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cell_valid[i] = (r_count > CW'(i));
            le[i]         = cell_valid[i] && (r_qprio[i] <= i_op.prio);
            id_hit[i]     = cell_valid[i] && (r_qid[i] == i_op.id);
        end
    end

    always_comb begin
        n_status    = i_op.status;
        n_head_id   = '0;
        n_head_prio = '0;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        unique case (i_op.kind)
            prq_pkg::OP_ENQ: begin
                if (|id_hit) begin
                    n_status = prq_pkg::ST_QUEUED;
                end else if (q_full) begin
                    n_status = prq_pkg::ST_FULL;
                end else begin
                    n_status = prq_pkg::ST_OK;
                    do_ins   = o_op_take;
                end
            end
            prq_pkg::OP_DEQ: begin
                if (r_count == '0) begin
                    n_status = prq_pkg::ST_EMPTY;
                end else begin
                    n_status    = prq_pkg::ST_OK;
                    n_head_id   = r_qid[0];
                    n_head_prio = r_qprio[0];
                    do_del      = o_op_take;
                end
            end
            default: begin
                n_status = i_op.status;
            end
        endcase
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (do_ins && !le[0]) begin
                    r_qid[0]   <= i_op.id;
                    r_qprio[0] <= i_op.prio;
                end else if (do_del && QUEUE_DEPTH > 1) begin
                    r_qid[0]   <= r_qid[(QUEUE_DEPTH > 1) ? 1 : 0];
                    r_qprio[0] <= r_qprio[(QUEUE_DEPTH > 1) ? 1 : 0];
                end
            end
        end else if (i == QUEUE_DEPTH - 1) begin : g_last
            always_ff @(posedge i_clk) begin
                if (do_ins && !le[i]) begin
                    if (le[i-1]) begin
                        r_qid[i]   <= i_op.id;
                        r_qprio[i] <= i_op.prio;
                    end else begin
                        r_qid[i]   <= r_qid[i-1];
                        r_qprio[i] <= r_qprio[i-1];
                    end
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (do_ins && !le[i]) begin
                    if (le[i-1]) begin
                        r_qid[i]   <= i_op.id;
                        r_qprio[i] <= i_op.prio;
                    end else begin
                        r_qid[i]   <= r_qid[i-1];
                        r_qprio[i] <= r_qprio[i-1];
                    end
                end else if (do_del) begin
                    r_qid[i]   <= r_qid[i+1];
                    r_qprio[i] <= r_qprio[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_ins) begin
                r_count <= r_count + 1'b1;
            end else if (do_del) begin
                r_count <= r_count - 1'b1;
            end
            if (o_op_take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_take) begin
            r_status    <= n_status;
            r_head_id   <= n_head_id;
            r_head_prio <= n_head_prio;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_status        = r_status;
    assign o_head_id       = r_head_id;
    assign o_head_priority = r_head_prio;

endmodule

// ----- sv/priority_ready_queue_with_registry.sv -----
// Top level of the priority ready queue with task registry.
// Commands enter through push/full and results leave through empty/pop, one result word per
// command in command order. The front end checks and updates the task registry in the cycle a
// command is accepted, using one parallel compare over all registry entries; a two-entry command
// queue then feeds the back end, which inserts into or shifts the sorted queue cells with a
// parallel compare over the cells and loads the result register. A command is accepted every
// cycle while the command queue has room, and its result reaches the result ports by way of
// the command queue and then the result register; a result that is not popped holds the back
// end, and once the command queue fills, full rises. No clearing pass is needed after reset.
module priority_ready_queue_with_registry #(
    parameter int REGISTRY_DEPTH = prq_pkg::REGISTRY_DEPTH_DEF,
    parameter int QUEUE_DEPTH    = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_kind,
    input  logic [prq_pkg::ID_W-1:0]    i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]  i_task_priority,
    output logic                        empty,
    input  logic                        pop,
    output logic [2:0]                  o_status,
    output logic [prq_pkg::ID_W-1:0]    o_head_id,
    output logic [prq_pkg::PRIO_W-1:0]  o_head_priority
);

    logic         accept;
    prq_pkg::t_op front_op;
    logic         fifo_valid;
    prq_pkg::t_op fifo_op;
    logic         back_take;

    assign accept = push && !full;

    prq_front #(
        .REGISTRY_DEPTH (REGISTRY_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_kind          (i_kind),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .o_op            (front_op)
    );

    prq_op_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .o_full  (full),
        .o_valid (fifo_valid),
        .o_op    (fifo_op),
        .i_pop   (back_take)
    );

    prq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (fifo_valid),
        .i_op            (fifo_op),
        .o_op_take       (back_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_status        (o_status),
        .o_head_id       (o_head_id),
        .o_head_priority (o_head_priority)
    );

endmodule

// ----- sv/prq_checker.sv -----
// Port-level checker for the priority ready queue, bound to the top level.
module prq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [2:0]                  o_status,
    input logic [prq_pkg::ID_W-1:0]    o_head_id,
    input logic [prq_pkg::PRIO_W-1:0]  o_head_priority
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= prq_pkg::ST_FULL))
        else $error("status code out of range");

    a_zero_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != prq_pkg::ST_OK) |-> (o_head_id == '0 && o_head_priority == '0))
        else $error("failed command carries head fields");

    a_head_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_head_id == '0) == (o_head_priority == '0)))
        else $error("head id and priority disagree on zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_head_id)))
        else $error("stalled result word changed");

endmodule

bind priority_ready_queue_with_registry prq_checker u_prq_checker (.*);

// ----- tb/prq_result_checker.sv -----
// Result checker for the priority ready queue: predicts each command's answer and compares.
`timescale 1ns / 100ps

module prq_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [1:0]                 i_kind,
    input  logic [prq_pkg::ID_W-1:0]   i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0] i_task_priority,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [2:0]                 i_status,
    input  logic [prq_pkg::ID_W-1:0]   i_head_id,
    input  logic [prq_pkg::PRIO_W-1:0] i_head_priority,
    output int                         o_pending,
    output int                         o_fail_count
);

    localparam int REG_N   = prq_pkg::REGISTRY_DEPTH_DEF;
    localparam int READY_N = prq_pkg::QUEUE_DEPTH_DEF;

    typedef struct packed {
        prq_pkg::t_status           status;
        logic [prq_pkg::ID_W-1:0]   id;
        logic [prq_pkg::PRIO_W-1:0] prio;
    } t_answer;

    bit                         registry_used [REG_N];
    logic [prq_pkg::ID_W-1:0]   registry_ids  [REG_N];
    logic [prq_pkg::PRIO_W-1:0] registry_prios[REG_N];
    logic [prq_pkg::ID_W-1:0]   ready_ids[$];
    logic [prq_pkg::PRIO_W-1:0] ready_prios[$];
    t_answer                    answers_due[$];
    int                         mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic t_answer schedule_command(input prq_pkg::t_kind k,
                                                 input logic [prq_pkg::ID_W-1:0] id,
                                                 input logic [prq_pkg::PRIO_W-1:0] prio);
        t_answer ans;
        int      slot;
        int      free_slot;
        int      pos;
        bit      queued;
        ans       = '{status: prq_pkg::ST_OK, id: '0, prio: '0};
        slot      = -1;
        free_slot = -1;
        queued    = 1'b0;
        for (int i = 0; i < REG_N; i++) begin
            if (slot < 0 && registry_used[i] && registry_ids[i] == id) slot = i;
            if (free_slot < 0 && !registry_used[i]) free_slot = i;
        end
        case (k)
            prq_pkg::KIND_REGISTER: begin
                if (id == '0 || prio == '0) ans.status = prq_pkg::ST_INVALID;
                else if (slot >= 0) ans.status = prq_pkg::ST_DUPLICATE;
                else if (free_slot < 0) ans.status = prq_pkg::ST_FULL;
                else begin
                    registry_used[free_slot]  = 1'b1;
                    registry_ids[free_slot]   = id;
                    registry_prios[free_slot] = prio;
                end
            end
            prq_pkg::KIND_REMOVE: begin
                if (id == '0) ans.status = prq_pkg::ST_INVALID;
                else if (slot < 0) ans.status = prq_pkg::ST_NOT_FOUND;
                else registry_used[slot] = 1'b0;
            end
            prq_pkg::KIND_ENQUEUE: begin
                foreach (ready_ids[i]) if (ready_ids[i] == id) queued = 1'b1;
                if (id == '0) ans.status = prq_pkg::ST_INVALID;
                else if (slot < 0) ans.status = prq_pkg::ST_NOT_FOUND;
                else if (queued) ans.status = prq_pkg::ST_QUEUED;
                else if (ready_ids.size() >= READY_N) ans.status = prq_pkg::ST_FULL;
                else begin
                    pos = 0;
                    while (pos < ready_ids.size() && ready_prios[pos] <= registry_prios[slot])
                        pos++;
                    ready_ids.insert(pos, id);
                    ready_prios.insert(pos, registry_prios[slot]);
                end
            end
            default: begin
                if (ready_ids.size() == 0) ans.status = prq_pkg::ST_EMPTY;
                else begin
                    ans.id   = ready_ids.pop_front();
                    ans.prio = ready_prios.pop_front();
                end
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (registry_used[i]) registry_used[i] = 1'b0;
            ready_ids.delete();
            ready_prios.delete();
            answers_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result word with none expected: status %0d id %h prio %h",
                             $time, i_status, i_head_id, i_head_priority);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                        mismatches++;
                    end
                    if (i_head_id !== want.id) begin
                        $display("%0t: head_id expected %h actual %h",
                                 $time, want.id, i_head_id);
                        mismatches++;
                    end
                    if (i_head_priority !== want.prio) begin
                        $display("%0t: head_priority expected %h actual %h",
                                 $time, want.prio, i_head_priority);
                        mismatches++;
                    end
                end
            end
            if (i_push && !i_full)
                answers_due.push_back(schedule_command(prq_pkg::t_kind'(i_kind), i_task_id,
                                                       i_task_priority));
        end
        o_pending    <= answers_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/tb_priority_ready_queue_with_registry.sv -----
// Testbench top for the priority ready queue: drives commands, pops results, reports the verdict.
`timescale 1ns / 100ps

module tb_priority_ready_queue_with_registry;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int POOL_N        = 22;
    localparam int PHASE_ITEMS   = 300;
    localparam int DRAIN_CYCLES  = 10;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic [1:0]                 kind;
    logic [prq_pkg::ID_W-1:0]   task_id;
    logic [prq_pkg::PRIO_W-1:0] task_prio;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [2:0]                 status;
    logic [prq_pkg::ID_W-1:0]   head_id;
    logic [prq_pkg::PRIO_W-1:0] head_prio;

    int                         pending;
    int                         fail_count;
    int                         cycle_count;
    int                         tx_idle;
    int                         rx_idle;
    logic [prq_pkg::ID_W-1:0]   id_pool[POOL_N];

    priority_ready_queue_with_registry DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (kind),
        .i_task_id       (task_id),
        .i_task_priority (task_prio),
        .empty           (empty),
        .pop             (pop),
        .o_status        (status),
        .o_head_id       (head_id),
        .o_head_priority (head_prio)
    );

    prq_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_kind          (kind),
        .i_task_id       (task_id),
        .i_task_priority (task_prio),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_status        (status),
        .i_head_id       (head_id),
        .i_head_priority (head_prio),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send_command(input prq_pkg::t_kind k, input logic [prq_pkg::ID_W-1:0] id,
                                input logic [prq_pkg::PRIO_W-1:0] prio);
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        kind      <= k;
        task_id   <= id;
        task_prio <= prio;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic random_command(input bit filling);
        int                         roll;
        prq_pkg::t_kind             k;
        logic [prq_pkg::ID_W-1:0]   id;
        logic [prq_pkg::PRIO_W-1:0] prio;
        roll = $urandom_range(99);
        if (filling)
            k = (roll < 35) ? prq_pkg::KIND_REGISTER : (roll < 42) ? prq_pkg::KIND_REMOVE :
                (roll < 85) ? prq_pkg::KIND_ENQUEUE : prq_pkg::KIND_DEQUEUE;
        else
            k = (roll < 12) ? prq_pkg::KIND_REGISTER : (roll < 32) ? prq_pkg::KIND_REMOVE :
                (roll < 47) ? prq_pkg::KIND_ENQUEUE : prq_pkg::KIND_DEQUEUE;
        roll = $urandom_range(99);
        if (roll < 3) id = '0;
        else if (roll < 8) id = prq_pkg::ID_W'($urandom_range(1, 65535));
        else id = id_pool[$urandom_range(POOL_N - 1)];
        roll = $urandom_range(99);
        if (roll < 3) prio = '0;
        else if (roll < 15) prio = prq_pkg::PRIO_W'($urandom_range(1, 65535));
        else prio = prq_pkg::PRIO_W'($urandom_range(1, 6));
        send_command(k, id, prio);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) random_command(((n / 40) % 2) == 0);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        push      = 1'b0;
        kind      = prq_pkg::KIND_REGISTER;
        task_id   = '0;
        task_prio = '0;
        tx_idle   = 37;
        rx_idle   = 56;
        foreach (id_pool[i]) id_pool[i] = prq_pkg::ID_W'($urandom_range(1, 65535));
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(prq_pkg::KIND_DEQUEUE,  prq_pkg::ID_W'($urandom),
                     prq_pkg::PRIO_W'($urandom));
        send_command(prq_pkg::KIND_REGISTER, 16'h0000, 16'h0003);
        send_command(prq_pkg::KIND_REGISTER, 16'h0009, 16'h0000);
        send_command(prq_pkg::KIND_REMOVE,   16'h0000, 16'h0001);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h0000, 16'h0001);
        send_command(prq_pkg::KIND_REGISTER, 16'hFFFF, 16'hFFFF);
        send_command(prq_pkg::KIND_REGISTER, 16'h0001, 16'h0001);
        send_command(prq_pkg::KIND_REGISTER, 16'h0001, 16'h0002);
        send_command(prq_pkg::KIND_REMOVE,   16'h1234, 16'h0000);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h1234, 16'h0000);
        send_command(prq_pkg::KIND_ENQUEUE,  16'hFFFF, 16'h0000);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h0001, 16'h0000);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h0001, 16'h0000);
        send_command(prq_pkg::KIND_REGISTER, 16'h0005, 16'hFFFF);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h0005, 16'h0000);
        send_command(prq_pkg::KIND_REMOVE,   16'h0001, 16'h0000);
        send_command(prq_pkg::KIND_REGISTER, 16'h0001, 16'h0007);
        send_command(prq_pkg::KIND_ENQUEUE,  16'h0001, 16'h0000);
        repeat (4) send_command(prq_pkg::KIND_DEQUEUE, prq_pkg::ID_W'($urandom),
                                prq_pkg::PRIO_W'($urandom));
        send_command(prq_pkg::KIND_REMOVE,   16'hFFFF, 16'h0000);
        send_command(prq_pkg::KIND_REMOVE,   16'h0005, 16'h0000);
        send_command(prq_pkg::KIND_REMOVE,   16'h0001, 16'h0000);

        run_random(PHASE_ITEMS);
        tx_idle = 56;
        rx_idle = 37;
        run_random(PHASE_ITEMS);
        tx_idle = 0;
        rx_idle = 0;
        run_random(PHASE_ITEMS);
        push <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
